// File: hdl/des_pkg.sv
`default_nettype none
package des_pkg;

    localparam int unsigned BlockW = 64;
    localparam int unsigned KeyW   = 64;
    localparam int unsigned RkW    = 48;
    localparam int unsigned Rounds = 16;
    localparam int unsigned CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CFG_KEY  = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_MODE = 1'b1;

    typedef logic [63:0] t_block;
    typedef logic [47:0] t_rkey;
    typedef logic [27:0] t_half28;

    typedef logic [6:0] t_tab64 [64];
    typedef logic [5:0] t_tab48 [48];
    typedef logic [5:0] t_tab32 [32];
    typedef logic [5:0] t_tab56 [56];

    localparam t_tab64 PERM_IP = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

    localparam t_tab64 PERM_FP = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

    localparam t_tab48 PERM_E = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1 };

    localparam t_tab32 PERM_P = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25 };

    localparam t_tab56 PERM_PC1 = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };

    localparam t_tab48 PERM_PC2 = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32 };

    localparam logic [15:0] ROT_TWO = 16'b0011_1111_0111_1110;

    typedef logic [3:0] t_sbox [8][64];
    localparam t_sbox SBOX = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

    function automatic t_block ip_perm(input t_block x);
        t_block r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-PERM_IP[i]];
        return r;
    endfunction

    function automatic t_block fp_perm(input t_block x);
        t_block r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-PERM_FP[i]];
        return r;
    endfunction

    function automatic logic [55:0] pc1_perm(input t_block x);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = x[64-PERM_PC1[i]];
        return r;
    endfunction

    function automatic t_rkey pc2_perm(input logic [55:0] x);
        t_rkey r;
        for (int i = 0; i < 48; i++) r[47-i] = x[56-PERM_PC2[i]];
        return r;
    endfunction

    function automatic t_half28 rot28(input t_half28 x, input logic two);
        return two ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input t_rkey k);
        t_rkey       e;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) e[47-i] = r[32-PERM_E[i]];
        e = e ^ k;
        for (int b = 0; b < 8; b++) begin
            six = e[47-6*b -: 6];
            s[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-PERM_P[i]];
        return p;
    endfunction

endpackage
`default_nettype wire

// File: hdl/des_if.sv
`default_nettype none
interface des_blk_if;
    logic                valid;
    logic                ready;
    logic [63:0]         data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface des_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/des_block_cipher_ecb.sv
`default_nettype none
// DES engine, ECB mode, one 64-bit block per transfer.
// Channels: i_blk (sink) carries block_in, o_blk (source) carries block_out,
// i_cfg writes index 0 = cipher_key (64 bits, parity ignored) and
// index 1 = decrypt_mode (bit 0). The user must write configuration only
// while idle; the block does not enforce this. Structure: an input
// register after the initial permutation, then one pipeline stage per
// Feistel round, 16 stages. The final permutation is wiring on the last
// stage. Throughput is one block per cycle while the output is not stalled.
// Round keys are computed combinationally from the written key data and
// held in a 16-entry register file that is loaded on a key write.
// A stall on the output holds the full stages behind it up to the nearest
// bubble; a bubble inside is filled while stalled, so nothing is lost or repeated.
// Reset clears the valid bits and the round keys to zero (the schedule of
// the all-zero key), and sets encryption mode. Configuration writes are always ready.
module des_block_cipher_ecb
    import des_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    des_cfg_if.sink   i_cfg,
    des_blk_if.sink   i_blk,
    des_blk_if.source o_blk
);

    t_rkey       r_rk [Rounds];
    t_rkey       n_rk [Rounds];
    logic        r_dec;
    logic [31:0] r_l [Rounds+1];
    logic [31:0] r_r [Rounds+1];
    logic        r_v [Rounds+1];
    logic        adv [Rounds+1];
    logic [55:0] cd;
    t_half28     c, d;
    t_block      ip_in;

    always_comb begin
        cd = pc1_perm(i_cfg.data);
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < Rounds; i++) begin
            c = rot28(c, ROT_TWO[15-i]);
            d = rot28(d, ROT_TWO[15-i]);
            n_rk[i] = pc2_perm({c, d});
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Rounds; i++) r_rk[i] <= '0;
            r_dec <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_KEY:  r_rk <= n_rk;
                CFG_MODE: r_dec <= i_cfg.data[0];
                default:  ;
            endcase
        end
    end

    // Stage s is free to load when it is empty or its content moves on.
    always_comb begin
        adv[Rounds] = !r_v[Rounds] || o_blk.ready;
        for (int s = Rounds - 1; s >= 0; s--) adv[s] = !r_v[s] || adv[s+1];
    end

    assign i_blk.ready = adv[0];
    assign ip_in = ip_perm(i_blk.data);

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_l[0] <= ip_in[63:32];
            r_r[0] <= ip_in[31:0];
        end
        for (int s = 1; s <= Rounds; s++) begin
            if (adv[s]) begin
                r_l[s] <= r_r[s-1];
                r_r[s] <= r_l[s-1] ^ feistel(r_r[s-1],
                          r_rk[r_dec ? 4'(Rounds - s) : 4'(s - 1)]);
            end
        end
        if (!i_rst_n) begin
            for (int s = 0; s <= Rounds; s++) r_v[s] <= 1'b0;
        end else begin
            if (adv[0]) r_v[0] <= i_blk.valid;
            for (int s = 1; s <= Rounds; s++) if (adv[s]) r_v[s] <= r_v[s-1];
        end
    end

    assign o_blk.valid = r_v[Rounds];
    assign o_blk.data  = fp_perm({r_r[Rounds], r_l[Rounds]});

    ast_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_blk.valid && !o_blk.ready |=> o_blk.valid && $stable(o_blk.data))
        else $error("result changed while stalled");
    ast_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_blk.valid |-> i_blk.ready)
        else $error("input blocked with empty output");
    ast_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[Rounds-1] && adv[Rounds] |=> o_blk.valid)
        else $error("item lost in last stage");

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import des_pkg::*;

    localparam int LATENCY = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1130;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    des_cfg_if cfg_ch ();
    des_blk_if in_ch ();
    des_blk_if out_ch ();

    des_block_cipher_ecb dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch.sink),
        .i_blk  (in_ch.sink),
        .o_blk  (out_ch.source)
    );

    // Predictor state: key schedule and direction.
    t_rkey  sched [16];
    logic   decrypting;
    t_block expected_blocks [$];
    int     mismatch_count = 0;
    int     idle_cycles = 0;
    bit     gaps_on = 1'b1;
    bit     hold_sink = 1'b0;
    bit     timed_out = 1'b0;

    typedef struct {
        logic   has_golden;
        t_block data;
        t_block golden;
    } t_dir_row;

    function automatic t_block apply_ip(input t_block x);
        t_block r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-PERM_IP[i]];
        return r;
    endfunction

    function automatic t_block apply_fp(input t_block x);
        t_block r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-PERM_FP[i]];
        return r;
    endfunction

    function automatic logic [31:0] round_mix(input logic [31:0] half, input t_rkey k);
        logic [47:0] ex;
        logic [31:0] sub;
        logic [31:0] res;
        logic [5:0]  six;
        logic [1:0]  row;
        for (int i = 0; i < 48; i++) ex[47-i] = half[32-PERM_E[i]];
        ex ^= k;
        for (int b = 0; b < 8; b++) begin
            six = ex[47-6*b -: 6];
            row = {six[5], six[0]};
            sub[31-4*b -: 4] = SBOX[b][row*16 + six[4:1]];
        end
        for (int i = 0; i < 32; i++) res[31-i] = sub[32-PERM_P[i]];
        return res;
    endfunction

    function automatic void load_schedule(input logic [63:0] key);
        logic [55:0] cd;
        t_half28 c;
        t_half28 d;
        t_rkey rk;
        int sh;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64-PERM_PC1[i]];
        c = cd[55:28];
        d = cd[27:0];
        for (int r = 0; r < 16; r++) begin
            sh = (r == 0 || r == 1 || r == 8 || r == 15) ? 1 : 2;
            repeat (sh) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            cd = {c, d};
            for (int i = 0; i < 48; i++) rk[47-i] = cd[56-PERM_PC2[i]];
            sched[r] = rk;
        end
    endfunction

    function automatic t_block des_transform(input t_block blk);
        t_block ip;
        logic [31:0] lh;
        logic [31:0] rh;
        logic [31:0] tmp;
        ip = apply_ip(blk);
        lh = ip[63:32];
        rh = ip[31:0];
        for (int i = 0; i < 16; i++) begin
            tmp = rh;
            rh = lh ^ round_mix(rh, sched[decrypting ? 15 - i : i]);
            lh = tmp;
        end
        return apply_fp({rh, lh});
    endfunction

    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_KEY;
        cfg_ch.data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // Sink side: random stall bursts, plus a long hold-off when requested.
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                out_ch.ready <= 1'b0;
                @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 4);
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_block want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_blocks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected block_out %h", out_ch.data);
            end else begin
                want = expected_blocks.pop_front();
                if (out_ch.data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("block_out mismatch: expected %h actual %h",
                                 want, out_ch.data);
                end
            end
        end
    end

    // Watchdog: counts cycles with no transfer anywhere.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_KEY) load_schedule(value);
        else decrypting = value[0];
    endtask

    task automatic drain();
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Offers one block; sender gaps are inserted before it.
    task automatic send_block(input t_block blk, input logic check_golden,
                              input t_block golden);
        t_block want;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        want = des_transform(blk);
        if (check_golden && want !== golden) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("known answer: expected %h predicted %h", golden, want);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= blk;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_blocks.push_back(want);
    endtask

    task automatic idle_input();
        in_ch.valid <= 1'b0;
    endtask

    function automatic t_block rand_block();
        t_block b;
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: b = '0;
            1: b = '1;
            default: ;
        endcase
        return b;
    endfunction

    initial begin
        t_dir_row rows [$];
        decrypting = 1'b0;
        load_schedule('0);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset state: all-zero key, encryption.
        rows = '{
            '{1'b1, 64'h0000000000000000, 64'h8CA64DE9C1B123A7},
            '{1'b0, 64'hFFFFFFFFFFFFFFFF, '0},
            '{1'b0, 64'h8000000000000000, '0},
            '{1'b0, 64'h0000000000000001, '0},
            '{1'b0, 64'h0123456789ABCDEF, '0}
        };
        foreach (rows[i]) send_block(rows[i].data, rows[i].has_golden, rows[i].golden);
        idle_input();
        drain();

        // Classic key, encryption and decryption of its known answer.
        write_reg(CFG_KEY, 64'h133457799BBCDFF1);
        rows = '{
            '{1'b1, 64'h0123456789ABCDEF, 64'h85E813540F0AB405},
            '{1'b0, 64'hAAAAAAAAAAAAAAAA, '0},
            '{1'b0, 64'h5555555555555555, '0}
        };
        foreach (rows[i]) send_block(rows[i].data, rows[i].has_golden, rows[i].golden);
        idle_input();
        drain();
        write_reg(CFG_MODE, 64'h1);
        rows = '{
            '{1'b1, 64'h85E813540F0AB405, 64'h0123456789ABCDEF},
            '{1'b0, 64'h0000000000000000, '0}
        };
        foreach (rows[i]) send_block(rows[i].data, rows[i].has_golden, rows[i].golden);
        idle_input();
        drain();
        // Wide mode value keeps only bit 0; all-ones key.
        write_reg(CFG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(CFG_KEY, 64'hFFFFFFFFFFFFFFFF);
        rows = '{
            '{1'b1, 64'hFFFFFFFFFFFFFFFF, 64'h7359B2163E4EDC58},
            '{1'b0, 64'h0000000000000000, '0}
        };
        foreach (rows[i]) send_block(rows[i].data, rows[i].has_golden, rows[i].golden);
        idle_input();
        drain();

        // Random phases with fresh settings; each ends in a drain.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_KEY, (ph == 0) ? 64'h0 : {$urandom, $urandom});
            write_reg(CFG_MODE, {$urandom, $urandom});
            if (ph == 2) begin
                fork
                    begin
                        hold_sink = 1'b1;
                        repeat (60) @(posedge i_clk);
                        hold_sink = 1'b0;
                    end
                join_none
            end
            if (ph == 6) gaps_on = 1'b0;
            repeat (RANDOM_ITEMS / 8) begin
                send_block(rand_block(), 1'b0, '0);
            end
            idle_input();
            drain();
        end

        repeat (LATENCY + 5) @(posedge i_clk);
        if (mismatch_count == 0 && expected_blocks.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// File: files.f
hdl/des_pkg.sv
hdl/des_if.sv
hdl/des_block_cipher_ecb.sv
bench/tb.sv
